### rtl/core/coalescing_prefetch_request_queue_core_defines.svh
// Assertion macros for the checker of the prefetch request queue.
`ifndef COALESCING_PREFETCH_REQUEST_QUEUE_CORE_DEFINES_SVH
`define COALESCING_PREFETCH_REQUEST_QUEUE_CORE_DEFINES_SVH
// Asserts an implication that is checked on every rising clock edge outside reset.
`define CPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpq check failed");
// Asserts an implication whose consequent is checked in the cycle after its antecedent.
`define CPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpq check failed");
`endif

### rtl/core/cpq_pkg.sv
// Package with the types and constants of the prefetch request queue.
`default_nettype none
package cpq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_POP_BURST = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PAGE_W = 26;
    localparam int ENTRY_W = PAGE_W + 8 + 16 + 32;

    localparam logic [1:0] OP_HINT = 2'd0;
    localparam logic [1:0] OP_POP = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [3:0] ST_ACCEPTED = 4'd0;
    localparam logic [3:0] ST_COAL_QUEUED = 4'd1;
    localparam logic [3:0] ST_COAL_BUSY = 4'd2;
    localparam logic [3:0] ST_INVALID = 4'd3;
    localparam logic [3:0] ST_FULL = 4'd4;
    localparam logic [3:0] ST_POPPED = 4'd5;
    localparam logic [3:0] ST_STALE = 4'd6;
    localparam logic [3:0] ST_EMPTY = 4'd7;
    localparam logic [3:0] ST_CANCEL_DONE = 4'd8;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_EXITING = 3'd1;
    localparam logic [2:0] CFG_LIMIT = 3'd2;
    localparam logic [2:0] CFG_SPACE = 3'd3;
    localparam logic [2:0] CFG_GEN = 3'd4;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [7:0]        space;
        logic [15:0]       generation;
        logic [31:0]       id;
    } entry_t;

    typedef struct packed {
        logic        en;
        logic [IDX_W-1:0] addr;
        entry_t      data;
    } mem_wr_t;
endpackage
`default_nettype wire

### rtl/core/cpq_entry_ram.sv
// Entry store of the queue: one write port, one registered read port.
`default_nettype none
module cpq_entry_ram
    import cpq_pkg::*;
(
    input  wire logic             clk,
    input  wire mem_wr_t          wr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);
    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### rtl/core/coalescing_prefetch_request_queue_core.sv
// Top level of the coalescing prefetch request queue.
// Requests arrive on the in channel (valid/stall): operation 0 is a hint,
// 1 a pop burst and 2 a cancel over [page_address, range_end) of one space.
// Results leave on the out channel (out_valid/out_stall), one per hint,
// cancel, empty pop or invalid operation and one per popped entry, with
// last_result on the final one. Configuration registers are written over
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user writes them only while
// the block is idle, which it does not enforce. cfg_ready is always high.
// Entries live in one RAM with a single registered read port. A hint that
// passes the enable, exiting and limit checks reads and checks each queued
// entry until one matches, else enqueues or refuses it in the write step. A
// pop reads, checks and emits each entry it pops, waiting on a stalled result.
// A cancel reads each entry once; survivors go back in order behind the head.
// One request is worked on at a time; in_stall is high while busy.
// A stalled result register holds its value and the sequencer waits.
// Reset clears head, level, request id counter and configuration; RAM
// contents are left undefined and only the data of queued slots is used.
`default_nettype none
module coalescing_prefetch_request_queue_core
    import cpq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [37:0] page_address,
    input  wire logic [38:0] range_end,
    input  wire logic [7:0]  space_tag,
    input  wire logic        entry_present,
    input  wire logic        entry_swapped,
    input  wire logic        entry_busy,
    input  wire logic [4:0]  pop_budget,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       status,
    output logic [37:0]      out_page,
    output logic [7:0]       out_space,
    output logic [15:0]      out_generation,
    output logic [31:0]      out_request_id,
    output logic [4:0]       canceled_count,
    output logic [4:0]       queue_level,
    output logic             last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [38:0] cfg_data
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CHECK = 6'b000100,
        S_WRITE = 6'b001000,
        S_EMIT  = 6'b010000,
        S_WAIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic enable_reg, exiting_reg;
    logic [38:0] limit_reg;
    logic [7:0] cur_space_reg;
    logic [15:0] cur_gen_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [1:0] op_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [11:0] offs_reg;
    logic [38:0] end_reg;
    logic [7:0] tag_reg;
    logic present_reg, swapped_reg, busy_reg;
    logic [CNT_W-1:0] budget_reg, budget_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [CNT_W-1:0] popped_reg, popped_next;
    logic last_pop_reg, last_pop_next;

    logic ov_reg, ov_next;
    logic [3:0] st_reg, st_next;
    entry_t oe_reg, oe_next;
    logic [CNT_W-1:0] cc_reg, cc_next, lvl_reg, lvl_next;
    logic last_reg, last_next;

    mem_wr_t wr;
    logic [IDX_W-1:0] rd_addr;
    entry_t rd_data;

    logic in_acc;
    logic [PAGE_W-1:0] in_page;
    logic [4:0] bud_clamp;
    logic [38:0] rd_va;
    logic out_free;

    cpq_entry_ram u_ram (
        .clk(clk), .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign in_acc = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free = !ov_reg || !out_stall;
    assign in_page = page_address[37:12];
    assign rd_va = {1'b0, rd_data.page, 12'd0};
    assign bud_clamp = (pop_budget > 5'(MAX_POP_BURST)) ? 5'(MAX_POP_BURST) : pop_budget;

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign out_page = {oe_reg.page, 12'd0};
    assign out_space = oe_reg.space;
    assign out_generation = oe_reg.generation;
    assign out_request_id = oe_reg.id;
    assign canceled_count = 5'(cc_reg);
    assign queue_level = 5'(lvl_reg);
    assign last_result = last_reg;

    always_comb
    begin
        logic [IDX_W-1:0] slot;
        logic stale;
        logic in_range;
        state_next = state_reg;
        head_next = head_reg;
        count_next = count_reg;
        next_id_next = next_id_reg;
        budget_next = budget_reg;
        scan_next = scan_reg;
        kept_next = kept_reg;
        popped_next = popped_reg;
        last_pop_next = last_pop_reg;
        ov_next = ov_reg && out_stall;
        st_next = st_reg;
        oe_next = oe_reg;
        cc_next = cc_reg;
        lvl_next = lvl_reg;
        last_next = last_reg;
        wr = '0;
        slot = head_reg + IDX_W'(scan_reg);
        rd_addr = slot;
        stale = 1'b0;
        in_range = (rd_data.space == tag_reg) && (rd_va >= {1'b0, page_reg, offs_reg})
            && (rd_va < end_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    scan_next = '0;
                    kept_next = '0;
                    popped_next = '0;
                    budget_next = (bud_clamp > 5'(count_reg)) ? count_reg : CNT_W'(bud_clamp);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
                if (op_reg == OP_HINT)
                begin
                    if (!enable_reg || exiting_reg || ({1'b0, page_reg, 12'd0} >= limit_reg))
                    begin
                        st_next = ST_INVALID;
                        state_next = S_EMIT;
                    end
                    else if (scan_reg == count_reg)
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (op_reg == OP_POP)
                begin
                    if (budget_reg == '0)
                    begin
                        st_next = ST_EMPTY;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        rd_addr = head_reg;
                        // The next entry may only load the result register once
                        // the previous result has left it.
                        if (!out_free)
                        begin
                            state_next = S_READ;
                        end
                    end
                end
                else if (op_reg == OP_CANCEL)
                begin
                    if (scan_reg == count_reg)
                    begin
                        st_next = ST_CANCEL_DONE;
                        cc_next = count_reg - kept_reg;
                        count_next = kept_reg;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    st_next = ST_INVALID;
                    state_next = S_EMIT;
                end
            end
            S_CHECK:
            begin
                if (op_reg == OP_HINT)
                begin
                    if (rd_data.space == cur_space_reg && rd_data.page == page_reg)
                    begin
                        st_next = ST_COAL_QUEUED;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else if (op_reg == OP_POP)
                begin
                    stale = (rd_data.generation != cur_gen_reg)
                        || (rd_data.space != cur_space_reg) || (rd_va >= limit_reg);
                    st_next = stale ? ST_STALE : ST_POPPED;
                    oe_next = rd_data;
                    head_next = head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    popped_next = popped_reg + 1'b1;
                    last_pop_next = (popped_reg + 1'b1 == budget_reg);
                    state_next = S_EMIT;
                end
                else
                begin
                    // Survivors are written back in order behind the head; the
                    // write slot never passes the read slot, so no unread entry
                    // is overwritten, even when the ring wraps.
                    if (!in_range)
                    begin
                        wr.en = 1'b1;
                        wr.addr = head_reg + IDX_W'(kept_reg);
                        wr.data = rd_data;
                        kept_next = kept_reg + 1'b1;
                    end
                    scan_next = scan_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_WRITE:
            begin
                if (!present_reg || !swapped_reg || busy_reg)
                begin
                    st_next = (present_reg && busy_reg) ? ST_COAL_BUSY : ST_INVALID;
                end
                else if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    wr.en = 1'b1;
                    wr.addr = head_reg + IDX_W'(count_reg);
                    wr.data = '{page: page_reg, space: cur_space_reg,
                                generation: cur_gen_reg, id: next_id_reg};
                    next_id_next = next_id_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    st_next = ST_ACCEPTED;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    lvl_next = count_reg;
                    if (!(op_reg == OP_POP && budget_reg != '0))
                    begin
                        oe_next = '0;
                    end
                    if (op_reg != OP_CANCEL || st_reg != ST_CANCEL_DONE)
                    begin
                        cc_next = '0;
                    end
                    if (op_reg == OP_POP && budget_reg != '0 && !last_pop_reg)
                    begin
                        last_next = 1'b0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        last_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            next_id_reg <= '0;
            ov_reg <= 1'b0;
            enable_reg <= 1'b0;
            exiting_reg <= 1'b0;
            limit_reg <= '0;
            cur_space_reg <= '0;
            cur_gen_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            count_reg <= count_next;
            next_id_reg <= next_id_next;
            ov_reg <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLE:  enable_reg <= cfg_data[0];
                    CFG_EXITING: exiting_reg <= cfg_data[0];
                    CFG_LIMIT:   limit_reg <= cfg_data;
                    CFG_SPACE:   cur_space_reg <= cfg_data[7:0];
                    CFG_GEN:     cur_gen_reg <= cfg_data[15:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        budget_reg <= budget_next;
        scan_reg <= scan_next;
        kept_reg <= kept_next;
        popped_reg <= popped_next;
        last_pop_reg <= last_pop_next;
        st_reg <= st_next;
        oe_reg <= oe_next;
        cc_reg <= cc_next;
        lvl_reg <= lvl_next;
        last_reg <= last_next;
        if (in_acc)
        begin
            op_reg <= operation;
            page_reg <= in_page;
            offs_reg <= page_address[11:0];
            end_reg <= range_end;
            tag_reg <= space_tag;
            present_reg <= entry_present;
            swapped_reg <= entry_swapped;
            busy_reg <= entry_busy;
        end
    end
endmodule
`default_nettype wire

### rtl/core/cpq_checker.sv
// Port checker for the prefetch request queue, bound to its top level.
`default_nettype none
`include "coalescing_prefetch_request_queue_core_defines.svh"
module cpq_checker
    import cpq_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] status,
    input wire logic [4:0] canceled_count,
    input wire logic [4:0] queue_level,
    input wire logic       last_result
);
    `CPQ_ASSERT_IMP(a_level_bound, out_valid, queue_level <= 5'(QUEUE_DEPTH))
    `CPQ_ASSERT_IMP(a_single_last, out_valid && status != ST_POPPED && status != ST_STALE, last_result)
    `CPQ_ASSERT_IMP(a_cancel_only, out_valid && status != ST_CANCEL_DONE, canceled_count == 5'd0)
    `CPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
endmodule

bind coalescing_prefetch_request_queue_core cpq_checker u_cpq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .canceled_count(canceled_count), .queue_level(queue_level),
    .last_result(last_result)
);
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the coalescing prefetch request queue.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import cpq_pkg::*;

    typedef struct packed {
        logic [3:0]  status;
        logic [37:0] page;
        logic [7:0]  space;
        logic [15:0] generation;
        logic [31:0] id;
        logic [4:0]  canceled;
        logic [4:0]  level;
        logic        last;
    } result_t;

    typedef struct {
        logic [1:0]  op;
        logic [37:0] addr;
        logic [38:0] rend;
        logic [7:0]  tag;
        logic        present;
        logic        swapped;
        logic        busy;
        logic [4:0]  budget;
        logic        has_exp;
        logic [3:0]  exp_status;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] operation = '0;
    logic [37:0] page_address = '0;
    logic [38:0] range_end = '0;
    logic [7:0] space_tag = '0;
    logic entry_present = 1'b0, entry_swapped = 1'b0, entry_busy = 1'b0;
    logic [4:0] pop_budget = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] status;
    logic [37:0] out_page;
    logic [7:0] out_space;
    logic [15:0] out_generation;
    logic [31:0] out_request_id;
    logic [4:0] canceled_count, queue_level;
    logic last_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [38:0] cfg_data = '0;

    always #5 clk = ~clk;

    coalescing_prefetch_request_queue_core dut (.*);

    // Shadow copy of the queue and its registers.
    entry_t q_mem[QUEUE_DEPTH];
    int unsigned q_head, q_count;
    logic [31:0] q_next_id;
    logic r_enable, r_exiting;
    logic [38:0] r_limit;
    logic [7:0] r_space;
    logic [15:0] r_gen;

    result_t expected_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit timed_out = 0;

    function automatic result_t blank_result(logic [3:0] st);
        result_t r;
        r = '0;
        r.status = st;
        r.level = q_count[4:0];
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [3:0] hint_outcome(request_t t);
        logic [37:0] va;
        entry_t e;
        va = {t.addr[37:12], 12'h000};
        if (!r_enable || r_exiting || {1'b0, va} >= r_limit)
            return ST_INVALID;
        for (int i = 0; i < q_count; i++)
            if (q_mem[(q_head + i) % QUEUE_DEPTH].space == r_space &&
                q_mem[(q_head + i) % QUEUE_DEPTH].page == va[37:12])
                return ST_COAL_QUEUED;
        if (!t.present || !t.swapped || t.busy)
            return (t.present && t.busy) ? ST_COAL_BUSY : ST_INVALID;
        if (q_count >= QUEUE_DEPTH)
            return ST_FULL;
        e.page = va[37:12];
        e.space = r_space;
        e.generation = r_gen;
        e.id = q_next_id;
        q_mem[(q_head + q_count) % QUEUE_DEPTH] = e;
        q_next_id++;
        q_count++;
        return ST_ACCEPTED;
    endfunction

    // Works out the results a request causes and queues them for checking.
    task automatic predict_request(request_t t);
        result_t r;
        int unsigned n, bud;
        entry_t e;
        entry_t kept[$];
        int unsigned removed;
        logic [38:0] va;
        case (t.op)
            OP_HINT: expected_results.push_back(blank_result(hint_outcome(t)));
            OP_POP:
            begin
                bud = t.budget > MAX_POP_BURST ? MAX_POP_BURST : t.budget;
                n = bud < q_count ? bud : q_count;
                if (n == 0)
                    expected_results.push_back(blank_result(ST_EMPTY));
                for (int i = 0; i < n; i++)
                begin
                    e = q_mem[q_head];
                    q_head = (q_head + 1) % QUEUE_DEPTH;
                    q_count--;
                    r = blank_result((e.generation != r_gen || e.space != r_space ||
                        {1'b0, e.page, 12'h000} >= r_limit) ? ST_STALE : ST_POPPED);
                    r.page = {e.page, 12'h000};
                    r.space = e.space;
                    r.generation = e.generation;
                    r.id = e.id;
                    r.last = (i + 1 == n);
                    expected_results.push_back(r);
                end
            end
            OP_CANCEL:
            begin
                removed = 0;
                for (int i = 0; i < q_count; i++)
                begin
                    e = q_mem[(q_head + i) % QUEUE_DEPTH];
                    va = {1'b0, e.page, 12'h000};
                    if (e.space == t.tag && va >= {1'b0, t.addr} && va < t.rend)
                        removed++;
                    else
                        kept.push_back(e);
                end
                foreach (kept[i])
                    q_mem[i] = kept[i];
                q_head = 0;
                q_count = kept.size();
                r = blank_result(ST_CANCEL_DONE);
                r.canceled = removed[4:0];
                expected_results.push_back(r);
            end
            default: expected_results.push_back(blank_result(ST_INVALID));
        endcase
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, out_page, out_space, out_generation, out_request_id,
                   canceled_count, queue_level, last_result};
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h, actual %h", want, got);
                end
            end
        end
    end

    // Output stall in random bursts.
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            out_stall <= 1'b0;
        else if (out_stall)
            out_stall <= ($urandom_range(0, 3) != 0);
        else
            out_stall <= ($urandom_range(0, 7) == 0);
    end

    // Watchdog on cycles with no request, result or register write accepted.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_register(logic [2:0] idx, logic [38:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ENABLE: r_enable = val[0];
            CFG_EXITING: r_exiting = val[0];
            CFG_LIMIT: r_limit = val;
            CFG_SPACE: r_space = val[7:0];
            default: r_gen = val[15:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Called at a falling edge; ends at a falling edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Called at a falling edge; ends at the falling edge after acceptance.
    task automatic send_request(request_t t);
        int first_err;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= t.op;
        page_address <= t.addr;
        range_end <= t.rend;
        space_tag <= t.tag;
        entry_present <= t.present;
        entry_swapped <= t.swapped;
        entry_busy <= t.busy;
        pop_budget <= t.budget;
        do @(posedge clk); while (in_stall);
        first_err = expected_results.size();
        predict_request(t);
        if (t.has_exp && expected_results[first_err].status !== t.exp_status)
        begin
            errors++;
            if (errors <= 10)
                $display("table row: expected status %0d, predicted %0d",
                         t.exp_status, expected_results[first_err].status);
        end
        @(negedge clk);
    endtask

    function automatic request_t make_request(logic [1:0] op, logic [37:0] addr,
                                             logic [38:0] rend, logic [7:0] tag,
                                             logic [2:0] flags, logic [4:0] bud,
                                             bit has_exp, logic [3:0] st);
        request_t t;
        t.op = op; t.addr = addr; t.rend = rend; t.tag = tag;
        t.present = flags[2]; t.swapped = flags[1]; t.busy = flags[0];
        t.budget = bud; t.has_exp = has_exp; t.exp_status = st;
        return t;
    endfunction

    // Random request mostly from a small set of pages so hints coalesce and cancels hit.
    function automatic request_t random_request(logic [7:0] cur_space);
        request_t t;
        int k;
        k = $urandom_range(0, 99);
        t = make_request(OP_HINT, 38'({$urandom, $urandom}), 0, 0,
                         3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), 0, 0);
        if ($urandom_range(0, 3) != 0)
            t.addr = {20'd0, 6'($urandom_range(0, 40)), 12'($urandom_range(0, 4095))};
        if (k < 60)
        begin
            if ($urandom_range(0, 2) != 0)
                {t.present, t.swapped, t.busy} = 3'b110;
        end
        else if (k < 82)
        begin
            t.op = OP_POP;
            if ($urandom_range(0, 2) != 0)
                t.budget = 5'($urandom_range(1, 4));
        end
        else if (k < 98)
        begin
            t.op = OP_CANCEL;
            t.tag = ($urandom_range(0, 3) != 0) ? cur_space : 8'($urandom);
            t.rend = ($urandom_range(0, 5) == 0) ? 39'({$urandom, $urandom}) :
                     {1'b0, t.addr[37:12] + 26'($urandom_range(0, 20)), 12'h000};
        end
        else
            t.op = 2'd3;
        return t;
    endfunction

    initial
    begin
        request_t plan[$];
        logic [38:0] top;
        r_enable = 0; r_exiting = 0; r_limit = 0; r_space = 0; r_gen = 0;
        q_head = 0; q_count = 0; q_next_id = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: hints refused, queue empty, nothing to cancel.
        plan.push_back(make_request(OP_HINT, 38'h1000, 0, 0, 3'b110, 0, 1, ST_INVALID));
        plan.push_back(make_request(OP_POP, 0, 0, 0, 0, 16, 1, ST_EMPTY));
        plan.push_back(make_request(OP_CANCEL, 0, 39'h40_0000_0000, 0, 0, 0, 1,
                                    ST_CANCEL_DONE));
        plan.push_back(make_request(2'd3, '1, '1, '1, 3'b111, '1, 1, ST_INVALID));
        foreach (plan[i])
            send_request(plan[i]);
        wait_drained();

        top = 39'h40_0000_0000;
        write_register(CFG_ENABLE, 1);
        write_register(CFG_EXITING, 0);
        write_register(CFG_LIMIT, top);
        write_register(CFG_SPACE, 8'hff);
        write_register(CFG_GEN, 16'hffff);
        plan.delete();
        plan.push_back(make_request(OP_HINT, '1, 0, 0, 3'b110, 0, 1, ST_ACCEPTED));
        plan.push_back(make_request(OP_HINT, 38'h3f_ffff_f000, 0, 0, 3'b110, 0, 1,
                                    ST_COAL_QUEUED));
        plan.push_back(make_request(OP_HINT, 0, 0, 0, 3'b010, 0, 1, ST_INVALID));
        plan.push_back(make_request(OP_HINT, 0, 0, 0, 3'b101, 0, 1, ST_COAL_BUSY));
        plan.push_back(make_request(OP_HINT, 0, 0, 0, 3'b111, 0, 1, ST_COAL_BUSY));
        plan.push_back(make_request(OP_HINT, 0, 0, 0, 3'b100, 0, 1, ST_INVALID));
        for (int i = 0; i < 16; i++)
            plan.push_back(make_request(OP_HINT, 38'h2000 * i + 38'h123, 0, 0, 3'b110,
                                        0, 0, 0));
        plan.push_back(make_request(OP_POP, 0, 0, 0, 0, 0, 1, ST_EMPTY));
        foreach (plan[i])
            send_request(plan[i]);
        wait_drained();

        // Change the space view so pops report stale entries.
        write_register(CFG_GEN, 16'h0001);
        write_register(CFG_LIMIT, 39'h1_0000);
        write_register(CFG_SPACE, 8'h00);
        plan.delete();
        plan.push_back(make_request(OP_POP, 0, 0, 0, 0, 31, 0, 0));
        plan.push_back(make_request(OP_CANCEL, 38'h10, 39'h10, 8'hff, 0, 0, 1,
                                    ST_CANCEL_DONE));
        plan.push_back(make_request(OP_CANCEL, 0, top, 8'hff, 0, 0, 1, ST_CANCEL_DONE));
        foreach (plan[i])
            send_request(plan[i]);
        wait_drained();
        write_register(CFG_EXITING, 1);
        send_request(make_request(OP_HINT, 38'h100, 0, 0, 3'b110, 0, 1, ST_INVALID));
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_register(CFG_ENABLE, phase != 3);
            write_register(CFG_EXITING, phase == 4);
            write_register(CFG_LIMIT, (phase == 2) ? 39'h1_0000 :
                           (phase == 1) ? top : 39'h3_0000 + $urandom_range(0, 39'h10000));
            write_register(CFG_SPACE, $urandom_range(0, 3) | ((phase == 5) ? 8'hfc : 8'h0));
            write_register(CFG_GEN, (phase == 5) ? 16'hffff : $urandom_range(0, 2));
            if (phase == 5)
                quiet = 1;
            for (int i = 0; i < 55; i++)
                send_request(random_request(r_space));
            wait_drained();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/cpq_pkg.sv
rtl/core/cpq_entry_ram.sv
rtl/core/coalescing_prefetch_request_queue_core.sv
rtl/core/cpq_checker.sv
dv/tb_top.sv
